/* src/lrde_pkg.sv */
package lrde_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_ACCEPTED  = 2'd0,
		KIND_DROPPED   = 2'd1,
		KIND_DELIVERED = 2'd2
	} kind_t;

	// Input function codes
	localparam logic FUNC_OFFER = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATE_LIMIT_ON     = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_BYTE_Q8 = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PROPAGATION_TICKS = 8'd2;
	localparam int unsigned CFG_DATA_W = 32;

	typedef struct packed {
		logic        func;
		logic [15:0] packet_bytes;
		logic [15:0] packet_tag;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] out_tag;
		logic [47:0] sender_free_at;
		logic        last;
	} out_item_t;

endpackage

/* src/link_rate_delay_emulator.sv */
// Link rate and delay emulator. Each input item is either a packet offer
// (func 0) or one time tick (func 1). An offer starts at the later of the
// current time and the end of the previous transmission, serializes for
// (packet_bytes * ticks_per_byte_q8) >> 8 ticks when the rate limit is on,
// and is queued with arrival = end of serialization + propagation_ticks; it
// answers one result (accepted, with the tick the sender is free again, or
// dropped when the queue is full). A tick advances time by one and delivers,
// in order, every head packet whose arrival is earlier than the new time, at
// most 16 per tick; a tick with nothing due answers nothing. All time sums
// saturate at the largest TIME_BITS value. Timing: the block takes one item
// at a time, in its idle step. An offer runs the steps accept, multiply, add
// and push, a drop accept, multiply and drop; a tick runs accept, advance and
// check, then per delivery a read step, for the registered read of the queue
// memory at the new head, and another check. Results leave through an output
// register, so the next item is taken while a result still waits; a step that
// must emit holds while that register is occupied and stalled. Configuration
// writes are always ready and must only be issued while the block is idle.
module link_rate_delay_emulator #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned TIME_BITS   = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input item channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  lrde_pkg::in_item_t                  item,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output lrde_pkg::out_item_t                 result,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lrde_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lrde_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import lrde_pkg::*;

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned NW = $clog2(MAX_RESULTS + 1);
	localparam int unsigned EW = TIME_BITS + 16;

	// ------------------------------------------------------------------
	// Microcode: one control word per step
	// ------------------------------------------------------------------
	typedef enum logic [2:0] {
		ST_IDLE, // wait for an item, branch on func
		ST_MUL,  // drop check, start time, serialization product
		ST_DONE, // end of serialization
		ST_PUSH, // queue the packet, report accepted
		ST_DROP, // report dropped
		ST_INC,  // advance time
		ST_CHK,  // test the head entry, pop if due
		ST_RD    // let the memory read at the new head settle
	} step_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LATCH,
		OP_MUL,
		OP_DONE,
		OP_PUSH,
		OP_DROP,
		OP_INC,
		OP_CHK
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,   // step + 1
		COND_JUMP,   // always to target
		COND_ACCEPT, // stay until transfer; tick to target, offer to step + 1
		COND_FULL,   // queue full to target, else step + 1
		COND_DUE     // head due to step + 1, else target
	} cond_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_ALWAYS,
		EM_PENDING
	} emit_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		emit_t emit;
		step_t target;
	} uword_t;

	function automatic uword_t urom(step_t s);
		uword_t w;
		w = '{op: OP_NOP, cond: COND_JUMP, emit: EM_NONE, target: ST_IDLE};
		case (s)
			ST_IDLE: w = '{op: OP_LATCH, cond: COND_ACCEPT, emit: EM_NONE, target: ST_INC};
			ST_MUL:  w = '{op: OP_MUL,   cond: COND_FULL,   emit: EM_NONE, target: ST_DROP};
			ST_DONE: w = '{op: OP_DONE,  cond: COND_JUMP,   emit: EM_NONE, target: ST_PUSH};
			ST_PUSH: w = '{op: OP_PUSH,  cond: COND_JUMP,   emit: EM_ALWAYS, target: ST_IDLE};
			ST_DROP: w = '{op: OP_DROP,  cond: COND_JUMP,   emit: EM_ALWAYS, target: ST_IDLE};
			ST_INC:  w = '{op: OP_INC,   cond: COND_NEXT,   emit: EM_NONE, target: ST_IDLE};
			ST_CHK:  w = '{op: OP_CHK,   cond: COND_DUE,    emit: EM_PENDING, target: ST_IDLE};
			ST_RD:   w = '{op: OP_NOP,   cond: COND_JUMP,   emit: EM_NONE, target: ST_CHK};
			default: w = '{op: OP_NOP,   cond: COND_JUMP,   emit: EM_NONE, target: ST_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [TIME_BITS-1:0] sat_add(
		input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b
	);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	step_t               step_q;
	logic                rate_on_q;
	logic [23:0]         tpb_q;
	logic [31:0]         prop_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] line_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [CW-1:0]       count_q;
	logic [NW-1:0]       n_q;
	logic                pend_q;
	logic [15:0]         pend_tag_q;
	logic                res_valid_q;
	out_item_t           res_q;

	// datapath registers (no reset)
	in_item_t            item_q;
	logic [TIME_BITS-1:0] start_q;
	logic [31:0]         ser_q;
	logic [TIME_BITS-1:0] done_q;

	// queue memory: {arrival, tag}
	logic [EW-1:0]       mem [QUEUE_DEPTH];
	logic [EW-1:0]       rd_q;

	uword_t              uw;
	logic                acc;
	logic                out_free;
	logic                emit_req;
	logic                hold;
	logic                res_set;
	logic                full;
	logic                due;
	logic                wr_en;
	logic [TIME_BITS-1:0] arrival;
	logic [TIME_BITS-1:0] rd_arrival;
	logic [15:0]         rd_tag;
	logic [39:0]         product;
	logic [63:0]         done_ext;
	logic [AW-1:0]       head_inc;
	logic [AW-1:0]       tail_inc;
	step_t               step_d;

	assign uw         = urom(step_q);
	assign item_stall = (step_q != ST_IDLE);
	assign acc        = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// output slot is free when empty or being drained this cycle
	assign out_free = !res_valid_q || !result_stall;
	assign emit_req = (uw.emit == EM_ALWAYS) || ((uw.emit == EM_PENDING) && pend_q);
	assign hold     = emit_req && !out_free;
	assign res_set  = emit_req && !hold;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign rd_arrival = rd_q[EW-1:16];
	assign rd_tag     = rd_q[15:0];
	assign due        = (count_q != '0) && (n_q < NW'(MAX_RESULTS)) && (rd_arrival < now_q);
	assign arrival    = sat_add(done_q, TIME_BITS'(prop_q));
	assign product    = 40'(item_q.packet_bytes) * 40'(tpb_q);
	assign done_ext   = 64'(done_q);
	assign wr_en      = (uw.op == OP_PUSH) && !hold;

	assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign tail_inc = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);

	// sequencer
	always_comb begin
		step_d = step_q;
		if (!hold) begin
			case (uw.cond)
				COND_NEXT:   step_d = step_t'(step_q + 3'd1);
				COND_JUMP:   step_d = uw.target;
				COND_ACCEPT: begin
					if (acc) begin
						step_d = (item.func == FUNC_TICK) ? uw.target : step_t'(step_q + 3'd1);
					end
				end
				COND_FULL:   step_d = full ? uw.target : step_t'(step_q + 3'd1);
				COND_DUE:    step_d = due ? step_t'(step_q + 3'd1) : uw.target;
				default:     step_d = ST_IDLE;
			endcase
		end
	end

	// control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			rate_on_q   <= 1'b0;
			tpb_q       <= 24'd256;
			prop_q      <= '0;
			now_q       <= '0;
			line_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			n_q         <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RATE_LIMIT_ON:     rate_on_q <= cfg_data[0];
					CFG_TICKS_PER_BYTE_Q8: tpb_q     <= cfg_data[23:0];
					CFG_PROPAGATION_TICKS: prop_q    <= cfg_data;
					default: ;
				endcase
			end

			// a new result refills the slot; otherwise a transfer empties it
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end

			if (!hold) begin
				case (uw.op)
					OP_PUSH: begin
						line_q  <= done_q;
						tail_q  <= tail_inc;
						count_q <= count_q + CW'(1);
					end
					OP_INC: begin
						now_q  <= sat_add(now_q, TIME_BITS'(1));
						n_q    <= '0;
						pend_q <= 1'b0;
					end
					OP_CHK: begin
						if (due) begin
							head_q  <= head_inc;
							count_q <= count_q - CW'(1);
							n_q     <= n_q + NW'(1);
							pend_q  <= 1'b1;
						end else begin
							pend_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath and result payload
	always_ff @(posedge clk) begin
		if (!hold) begin
			case (uw.op)
				OP_LATCH: begin
					if (acc) begin
						item_q <= item;
					end
				end
				OP_MUL: begin
					start_q <= (now_q > line_q) ? now_q : line_q;
					ser_q   <= rate_on_q ? product[39:8] : 32'd0;
				end
				OP_DONE: done_q <= sat_add(start_q, TIME_BITS'(ser_q));
				OP_PUSH: begin
					res_q.kind           <= KIND_ACCEPTED;
					res_q.out_tag        <= item_q.packet_tag;
					res_q.sender_free_at <= done_ext[47:0];
					res_q.last           <= 1'b1;
				end
				OP_DROP: begin
					res_q.kind           <= KIND_DROPPED;
					res_q.out_tag        <= item_q.packet_tag;
					res_q.sender_free_at <= '0;
					res_q.last           <= 1'b1;
				end
				OP_CHK: begin
					// pending delivery goes out once the next head is known
					if (pend_q) begin
						res_q.kind           <= KIND_DELIVERED;
						res_q.out_tag        <= pend_tag_q;
						res_q.sender_free_at <= '0;
						res_q.last           <= !due;
					end
					if (due) begin
						pend_tag_q <= rd_tag;
					end
				end
				default: ;
			endcase
		end
	end

	// queue memory, registered read at the head
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= {arrival, item_q.packet_tag};
		end
		rd_q <= mem[head_q];
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty queue with unequal pointers");

	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (now_q >= $past(now_q)))
		else $error("time went backwards");

	a_line_only_push: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en |=> $stable(line_q))
		else $error("line free time changed outside a push");
`endif

endmodule
